>>> sv/tklc_pkg.sv
// Shared types and constants for the tile key LRU cache.
package tklc_pkg;

  localparam int unsigned LAT_W = 8;
  localparam int unsigned LON_W = 9;
  localparam int unsigned KEY_W = LAT_W + LON_W;

  // Smallest capacity the register accepts.
  localparam logic [5:0] MIN_CAPACITY = 6'd25;

  // Tile key, latitude edge in the low bits.
  typedef struct packed {
    logic signed [LON_W-1:0] lon;
    logic signed [LAT_W-1:0] lat;
  } key_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PLACE,
    ST_UPDATE,
    ST_DONE
  } state_e;

endpackage

>>> sv/tile_key_lru_cache.sv
// Tile key LRU cache top level: sequencer, entry scan and result register.
//
// Fully associative LRU directory of tile keys. Requests arrive on the s_axis
// channel: tuser is the operation (0 lookup and touch, 1 insert after load),
// tdata carries the latitude and longitude edges. Each request produces one
// result transaction on m_axis: present, slot, evicted key and occupancy.
// A single store read port walks the entries one per cycle: a search pass
// finds the key, the oldest entry and the first free slot, then an update
// pass rewrites ages (and the new key) read-modify-write.
// The update pass is skipped on a lookup miss. s_axis_tready returns the
// cycle after the result is loaded, so one request is in flight.
// The result sits in an output register; if m_axis stalls, the next request
// is still taken and its scan runs, holding only at the final load.
// Reset, and any write to the capacity register, empties the directory at
// once (valid bits in flops); capacity resets to 25 and is clamped to
// 25..MAX_ENTRIES on write. Write capacity only while no request is open.
module tile_key_lru_cache
  import tklc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,       // capacity
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,    // lat_key[7:0], lon_key[16:8], zero pad
  input  logic        s_axis_tuser_i,    // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // present[0], slot[5:1], evicted_valid[6], evicted_lat[14:7],
  // evicted_lon[23:15], occupancy[29:24], zero pad
  output logic [31:0] m_axis_tdata_o
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [IW:0]   N_CNT    = (IW+1)'(MAX_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
  localparam logic [5:0]    MAX_CAP  = (MAX_ENTRIES > 63) ? 6'd63 : 6'(MAX_ENTRIES);

  state_e state_q, state_d;

  logic [CW-1:0]          cap_q;
  logic [CW-1:0]          count_q;
  logic [MAX_ENTRIES-1:0] valid_q;

  logic [IW:0]   cnt_q;
  logic          pipe_vld_q;
  logic [IW-1:0] pipe_idx_q;

  logic  op_q;
  key_t  key_q;

  logic          hit_q;
  logic [IW-1:0] hit_idx_q;
  logic [AW-1:0] hit_age_q;
  logic          vic_found_q;
  logic [IW-1:0] vic_idx_q;
  logic [AW-1:0] vic_age_q;
  key_t          vic_key_q;
  logic          free_found_q;
  logic [IW-1:0] free_idx_q;

  logic          place_q;
  logic          evict_q;
  logic [IW-1:0] new_slot_q;

  logic        m_tvalid_q;
  logic [31:0] m_tdata_q;

  key_t          rd_key;
  logic [AW-1:0] rd_age;

  logic          issue_rd;
  logic          scan_last;
  logic          out_load;
  logic          cur_valid;
  logic          wr_en;
  key_t          wr_key;
  logic [AW-1:0] wr_age;
  logic          evict_c;
  logic          place_c;
  logic [IW-1:0] new_slot_c;
  logic [5:0]    cap_sat;
  logic [4:0]    out_slot;
  key_t          out_ev_key;

  tklc_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (issue_rd),
    .rd_addr_i (cnt_q[IW-1:0]),
    .rd_key_o  (rd_key),
    .rd_age_o  (rd_age),
    .wr_en_i   (wr_en),
    .wr_addr_i (pipe_idx_q),
    .wr_key_i  (wr_key),
    .wr_age_i  (wr_age)
  );

  assign scan_last = pipe_vld_q && (pipe_idx_q == LAST_IDX);
  assign cur_valid = valid_q[pipe_idx_q];

  // Placement decision from the finished search pass.
  always_comb begin
    evict_c = !hit_q && op_q && (count_q >= cap_q) && vic_found_q;
    place_c = !hit_q && op_q && (evict_c || free_found_q);
    if (evict_c && !(free_found_q && (free_idx_q < vic_idx_q))) begin
      new_slot_c = vic_idx_q;
    end else begin
      new_slot_c = free_idx_q;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (scan_last) state_d = ST_PLACE;
      end
      ST_PLACE: begin
        if (hit_q || place_c) state_d = ST_UPDATE;
        else                  state_d = ST_DONE;
      end
      ST_UPDATE: begin
        if (scan_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    issue_rd        = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      ST_IDLE:   s_axis_tready_o = 1'b1;
      ST_SEARCH: issue_rd = (cnt_q < N_CNT);
      ST_UPDATE: issue_rd = (cnt_q < N_CNT);
      ST_DONE:   out_load = !m_tvalid_q || m_axis_tready_i;
      default:   s_axis_tready_o = 1'b0;
    endcase
  end

  // Age rewrite for the entry coming out of the store.
  always_comb begin
    wr_en  = 1'b0;
    wr_key = rd_key;
    wr_age = rd_age + 1'b1;
    if ((state_q == ST_UPDATE) && pipe_vld_q) begin
      if (hit_q) begin
        if (pipe_idx_q == hit_idx_q) begin
          wr_en  = 1'b1;
          wr_age = '0;
        end else if (cur_valid && (rd_age < hit_age_q)) begin
          wr_en = 1'b1;
        end
      end else if (place_q) begin
        if (pipe_idx_q == new_slot_q) begin
          wr_en  = 1'b1;
          wr_key = key_q;
          wr_age = '0;
        end else if (cur_valid && !(evict_q && (pipe_idx_q == vic_idx_q))) begin
          wr_en = 1'b1;
        end
      end
    end
  end

  always_comb begin
    cap_sat = cfg_wdata_i;
    if (cap_sat < MIN_CAPACITY) cap_sat = MIN_CAPACITY;
    if (cap_sat > MAX_CAP)      cap_sat = MAX_CAP;
  end

  always_comb begin
    if (hit_q)        out_slot = 5'(hit_idx_q);
    else if (place_q) out_slot = 5'(new_slot_q);
    else              out_slot = '0;
    out_ev_key = evict_q ? vic_key_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CW'(MIN_CAPACITY);
      count_q      <= '0;
      valid_q      <= '0;
      cnt_q        <= '0;
      pipe_vld_q   <= 1'b0;
      hit_q        <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      place_q      <= 1'b0;
      evict_q      <= 1'b0;
    end else begin
      pipe_vld_q <= issue_rd;
      if (issue_rd) cnt_q <= cnt_q + 1'b1;

      if (cfg_we_i) begin
        cap_q   <= CW'(cap_sat);
        count_q <= '0;
        valid_q <= '0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            cnt_q        <= '0;
            hit_q        <= 1'b0;
            vic_found_q  <= 1'b0;
            free_found_q <= 1'b0;
          end
        end
        ST_SEARCH: begin
          if (pipe_vld_q) begin
            if (cur_valid && (rd_key == key_q) && !hit_q) hit_q <= 1'b1;
            if (cur_valid && (!vic_found_q || (rd_age > vic_age_q))) vic_found_q <= 1'b1;
            if (!cur_valid && !free_found_q) free_found_q <= 1'b1;
          end
        end
        ST_PLACE: begin
          cnt_q   <= '0;
          place_q <= place_c;
          evict_q <= evict_c;
        end
        ST_UPDATE: begin
          if (scan_last && place_q) begin
            if (evict_q) valid_q[vic_idx_q] <= 1'b0;
            valid_q[new_slot_q] <= 1'b1;
            if (!evict_q) count_q <= count_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request and tracker payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid_i) begin
      op_q  <= s_axis_tuser_i;
      key_q <= key_t'(s_axis_tdata_i[KEY_W-1:0]);
    end
    if (state_q == ST_SEARCH && pipe_vld_q) begin
      if (cur_valid && (rd_key == key_q) && !hit_q) begin
        hit_idx_q <= pipe_idx_q;
        hit_age_q <= rd_age;
      end
      if (cur_valid && (!vic_found_q || (rd_age > vic_age_q))) begin
        vic_idx_q <= pipe_idx_q;
        vic_age_q <= rd_age;
        vic_key_q <= rd_key;
      end
      if (!cur_valid && !free_found_q) free_idx_q <= pipe_idx_q;
    end
    if (issue_rd) pipe_idx_q <= cnt_q[IW-1:0];
    if (state_q == ST_PLACE) new_slot_q <= new_slot_c;
    if (out_load) begin
      m_tdata_q <= {2'b00, 6'(count_q), out_ev_key.lon, out_ev_key.lat, evict_q,
                    out_slot, hit_q | place_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

endmodule

>>> sv/tklc_store.sv
// Entry store: key and age memory, one write and one registered read per cycle.
module tklc_store
  import tklc_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output key_t                     rd_key_o,
  output logic [AW-1:0]            rd_age_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  key_t                     wr_key_i,
  input  logic [AW-1:0]            wr_age_i
);

  key_t          key_mem [DEPTH];
  logic [AW-1:0] age_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      age_mem[wr_addr_i] <= wr_age_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o <= key_mem[rd_addr_i];
      rd_age_o <= age_mem[rd_addr_i];
    end
  end

endmodule

>>> sv/tklc_checker.sv
// Port-level checks for the tile key LRU cache, bound to the top level.
module tklc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // One request at a time: busy right after an accept.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while busy");

  // A miss reports slot zero and no eviction.
  a_miss_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[6:1] == 6'd0)
    else $error("miss with slot or eviction");

  // An eviction only comes with a placed key; no eviction means zero key.
  a_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[6] ? m_axis_tdata_o[0]
                                          : (m_axis_tdata_o[23:7] == 17'd0)))
    else $error("inconsistent eviction fields");

endmodule

bind tile_key_lru_cache tklc_checker u_tklc_checker (.*);

>>> dv/tb_tile_key_lru_cache.sv
// Tile key LRU cache testbench: directed and random traffic vs a behavioral directory.
`timescale 1ns / 100ps

module tb_tile_key_lru_cache;
  import tklc_pkg::*;

  localparam int unsigned MAX_ENTRIES  = 32;
  localparam int unsigned RAND_PER_CFG = 115;
  localparam int unsigned POOL_N       = 40;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 600_000;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef struct {
    op_e  op;
    key_t key;
  } tile_request_t;

  // Matches m_axis tdata layout, last field in the low bits.
  typedef struct packed {
    logic [1:0]              pad;
    logic [5:0]              occupancy;
    logic signed [LON_W-1:0] evicted_lon;
    logic signed [LAT_W-1:0] evicted_lat;
    logic                    evicted_valid;
    logic [4:0]              slot;
    logic                    present;
  } cache_reply_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [5:0]  cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;

  tile_key_lru_cache #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Behavioral directory state
  logic [MAX_ENTRIES-1:0] dir_valid;
  key_t                   dir_key [MAX_ENTRIES];
  int unsigned            dir_age [MAX_ENTRIES];
  int unsigned            dir_count;
  int unsigned            dir_capacity;

  tile_request_t tile_requests_q[$];
  cache_reply_t  cache_replies_q[$];
  key_t          key_pool [POOL_N];

  int unsigned issued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned fail_cnt     = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left    = 0;
  bit          hold_arm     = 1'b0;
  bit          hold_used    = 1'b0;

  function automatic void set_capacity(logic [5:0] value);
    int unsigned c;
    c = value;
    if (c < MIN_CAPACITY) c = MIN_CAPACITY;
    if (c > MAX_ENTRIES) c = MAX_ENTRIES;
    dir_capacity = c;
    dir_valid    = '0;
    dir_count    = 0;
  endfunction

  function automatic cache_reply_t predict_cache_reply(op_e op, key_t key);
    cache_reply_t r;
    int hit, victim, free_slot;
    int unsigned a;
    r = '0;
    hit = -1;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (hit < 0 && dir_valid[i] && dir_key[i] == key) hit = i;
    if (hit >= 0) begin
      // hit: promote to most recent, younger entries age by one
      a = dir_age[hit];
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (dir_valid[i] && dir_age[i] < a) dir_age[i]++;
      dir_age[hit] = 0;
      r.present = 1'b1;
      r.slot    = 5'(hit);
    end else if (op == OP_INSERT) begin
      if (dir_count >= dir_capacity) begin
        victim = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (dir_valid[i] && (victim < 0 || dir_age[i] > dir_age[victim])) victim = i;
        if (victim >= 0) begin
          r.evicted_valid   = 1'b1;
          r.evicted_lat     = dir_key[victim].lat;
          r.evicted_lon     = dir_key[victim].lon;
          dir_valid[victim] = 1'b0;
          dir_count--;
        end
      end
      free_slot = -1;
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (free_slot < 0 && !dir_valid[i]) free_slot = i;
      if (free_slot >= 0) begin
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (dir_valid[i]) dir_age[i]++;
        dir_valid[free_slot] = 1'b1;
        dir_key[free_slot]   = key;
        dir_age[free_slot]   = 0;
        dir_count++;
        r.present = 1'b1;
        r.slot    = 5'(free_slot);
      end
    end
    r.occupancy = 6'(dir_count);
    return r;
  endfunction

  function automatic void check_field(string name, int want, int seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, seen);
      fail_cnt++;
    end
  endfunction

  function automatic key_t grid_key();
    key_t k;
    int g;
    g = $urandom_range(11);
    k.lat = 8'(-75 + 15 * g);
    g = $urandom_range(23);
    k.lon = 9'(-180 + 15 * g);
    return k;
  endfunction

  function automatic key_t raw_key();
    key_t k;
    k.lat = 8'($urandom);
    k.lon = 9'($urandom);
    return k;
  endfunction

  // Working set larger than capacity: plenty of hits and evictions.
  function automatic void refill_pool();
    for (int i = 0; i < POOL_N; i++)
      key_pool[i] = ($urandom_range(9) == 0) ? raw_key() : grid_key();
  endfunction

  function automatic key_t pick_key();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return key_pool[$urandom_range(POOL_N - 1)];
    if (sel < 90) return grid_key();
    return raw_key();
  endfunction

  task automatic queue_request(op_e op, logic [7:0] lat, logic [8:0] lon);
    tile_request_t req;
    req.op      = op;
    req.key.lat = lat;
    req.key.lon = lon;
    tile_requests_q = {tile_requests_q, req};
    issued_cnt++;
  endtask

  task automatic queue_random();
    key_t k;
    k = pick_key();
    queue_request(($urandom_range(99) < 45) ? OP_INSERT : OP_LOOKUP, k.lat, k.lon);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (accepted_cnt != issued_cnt || cache_replies_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [5:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    set_capacity(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    tile_request_t req;
    cache_reply_t  pred;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pred = predict_cache_reply(op_e'(s_axis_tuser_i),
                                   key_t'(s_axis_tdata_i[KEY_W-1:0]));
        cache_replies_q = {cache_replies_q, pred};
        accepted_cnt++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tile_requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = tile_requests_q[0];
          tile_requests_q.delete(0);
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= req.op;
          s_axis_tdata_i  <= {{(24 - KEY_W){1'b0}}, req.key};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Reply monitor
  always @(posedge clk_i or negedge rst_ni) begin
    cache_reply_t seen, want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        seen = m_axis_tdata_o;
        if (cache_replies_q.size() == 0) begin
          $display("%0t: unexpected reply, expected none actual %h", $time, m_axis_tdata_o);
          fail_cnt++;
        end else begin
          want = cache_replies_q[0];
          cache_replies_q.delete(0);
          check_field("present", want.present, seen.present);
          check_field("slot", want.slot, seen.slot);
          check_field("evicted_valid", want.evicted_valid, seen.evicted_valid);
          check_field("evicted_lat", want.evicted_lat, seen.evicted_lat);
          check_field("evicted_lon", want.evicted_lon, seen.evicted_lon);
          check_field("occupancy", want.occupancy, seen.occupancy);
        end
      end
      m_axis_tready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    set_capacity(MIN_CAPACITY);
    send_idle_pct = 36;
    recv_idle_pct = 48;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty miss, edge keys, off-grid raw patterns, hit, resident insert
    queue_request(OP_LOOKUP, 0, 0);
    queue_request(OP_INSERT, -75, -180);
    queue_request(OP_INSERT, 90, 165);
    queue_request(OP_INSERT, 0, 0);
    queue_request(OP_INSERT, 8'h80, 9'h100);
    queue_request(OP_INSERT, 8'h7f, 9'h0ff);
    queue_request(OP_INSERT, 8'hff, 9'h1ff);
    queue_request(OP_INSERT, 8'h01, 9'h001);
    queue_request(OP_LOOKUP, -75, -180);
    queue_request(OP_INSERT, 90, 165);
    queue_request(OP_LOOKUP, 45, 45);
    queue_request(OP_LOOKUP, 8'h80, 9'h100);
    queue_request(OP_LOOKUP, 8'h7f, 9'h1ff);
    queue_request(OP_INSERT, 8'h7f, 9'h0ff);
    queue_request(OP_LOOKUP, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        wait_drained();
        case (ph)
          1: write_capacity(6'd63);
          2: write_capacity(6'd0);
          3: write_capacity(6'd32);
          4: write_capacity(6'd25);
          default: write_capacity(6'($urandom_range(63)));
        endcase
      end
      if (ph < 2) begin
        send_idle_pct = 36;
        recv_idle_pct = 48;
      end else if (ph < 4) begin
        send_idle_pct = 48;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 4) hold_arm = 1'b1;
      refill_pool();
      repeat (RAND_PER_CFG) queue_random();
    end

    wait_drained();
    repeat (2 * MAX_ENTRIES + 8) @(posedge clk_i);
    if (fail_cnt == 0 && cache_replies_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
